// ----- sv/fpts_pkg.sv -----
// fpts_pkg: shared types and codes for the fair per-source transmit scheduler
// no dependencies; imported by the top level, the checker and the testbench
`default_nettype none
package fpts_pkg;

    localparam int TAG_W    = 16;
    localparam int LEN_W    = 16;
    localparam int SRC_W    = 3;
    localparam int LIMIT_W  = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_PUSH_BROKER = 2'd0,
        OP_PUSH_SOURCE = 2'd1,
        OP_SEND        = 2'd2,
        OP_DESTROY     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PUSH_OK    = 2'd0,
        PUSH_FULL  = 2'd1,
        PUSH_ERROR = 2'd2,
        PUSH_RSVD  = 2'd3
    } t_push_result;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_BROKER    = 2'd1,
        KIND_SOURCE    = 2'd2,
        KIND_KEEPALIVE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_CONNECT    = 2'd1,
        ACT_DISCONNECT = 2'd2,
        ACT_INVALID    = 2'd3
    } t_final_action;

    typedef enum logic [1:0] {
        LINK_ACCEPTED = 2'd0,
        LINK_BLOCK    = 2'd1,
        LINK_ERROR    = 2'd2,
        LINK_UNKNOWN  = 2'd3
    } t_link_status;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITLESS   = 1'd1;

endpackage
`default_nettype wire

// ----- sv/fpts_ram.sv -----
// fpts_ram: single write port, single read port memory, registered read data
// depends on nothing
`default_nettype none
module fpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- sv/fpts_rr_pick.sv -----
// fpts_rr_pick: round-robin pick of the next nonempty source after the last one
// depends on nothing
`default_nettype none
module fpts_rr_pick #(
    parameter int SOURCES = 8
) (
    input  wire logic [SOURCES-1:0]         i_nonempty,
    input  wire logic [$clog2(SOURCES):0]   i_last,
    output logic                            o_found,
    output logic [$clog2(SOURCES)-1:0]      o_idx
);
    localparam int SW = $clog2(SOURCES);

    logic [SW:0] start;
    logic [SW:0] s;

    always_comb begin
        start = '0;
        s = '0;
        o_found = 1'b0;
        o_idx = '0;
        // start right after the last source; none or the top source wraps to zero
        if (i_last >= (SW+1)'(SOURCES - 1)) begin
            start = '0;
        end else begin
            start = i_last + 1'b1;
        end
        // walk downward so the nearest hit wins
        for (int k = SOURCES - 1; k >= 0; k--) begin
            s = start + (SW+1)'(k);
            if (s >= (SW+1)'(SOURCES)) begin
                s = s - (SW+1)'(SOURCES);
            end
            if (i_nonempty[s[SW-1:0]]) begin
                o_found = 1'b1;
                o_idx = s[SW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/fair_per_source_transmit_scheduler.sv -----
// fair_per_source_transmit_scheduler: top level, descriptor lists in two memories
// uses fpts_pkg, fpts_ram (descriptor and link memories) and fpts_rr_pick
// timing: an accepted item is latched with its memory reads; the result is
// registered from the execute cycle, with o_valid high; busy is high for one cycle,
// so a new item waits for the read-modify-write of the descriptor and link memories
// reset: synchronous active low, all lists empty, pool free, registers to reset values
`default_nettype none
module fair_per_source_transmit_scheduler #(
    parameter int POOL_DEPTH = 64,
    parameter int SOURCES    = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [fpts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fpts_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [2:0]                    i_source_id,
    input  wire logic [15:0]                   i_message_tag,
    input  wire logic [15:0]                   i_message_length,
    input  wire logic [1:0]                    i_final_action,
    input  wire logic [1:0]                    i_link_status,
    input  wire logic [15:0]                   i_bytes_accepted,
    input  wire logic                          i_timer_expired,
    output logic                               o_valid,
    output logic [1:0]                         o_push_result,
    output logic [1:0]                         o_served_kind,
    output logic [2:0]                         o_served_source,
    output logic [15:0]                        o_served_tag,
    output logic [15:0]                        o_start_offset,
    output logic                               o_message_done,
    output logic                               o_restart_timer,
    output logic                               o_progress,
    output logic                               o_link_invalid
);
    import fpts_pkg::*;

    localparam int AW  = $clog2(POOL_DEPTH);
    localparam int CW  = AW + 1;
    localparam int SW  = $clog2(SOURCES);
    localparam int XW  = ((SW > SRC_W) ? SW : SRC_W) + 1;
    localparam int QW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int DW  = TAG_W + 2 * LEN_W;

    // configuration
    logic [LIMIT_W-1:0] r_queue_limit;
    logic               r_limitless;

    // list heads: broker list and one list per source
    logic [AW-1:0] r_b_head, r_b_tail;
    logic [CW-1:0] r_b_cnt;
    logic [AW-1:0] r_s_head [SOURCES];
    logic [AW-1:0] r_s_tail [SOURCES];
    logic [CW-1:0] r_s_cnt  [SOURCES];

    // free pool: a linked chain plus never-used entries from r_bump upward
    logic [AW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_bump, n_bump;
    logic [CW-1:0] r_total, n_total;
    logic [SW:0]   r_last, n_last;
    logic          r_destroyed, n_destroyed;
    logic          r_link_bad, n_link_bad;
    logic          r_busy;

    // latched item
    t_opcode       r_op;
    logic [2:0]    r_src;
    logic [15:0]   r_tag, r_len, r_bytes;
    t_final_action r_act;
    t_link_status  r_status;
    t_kind         r_kind;
    logic [SW-1:0] r_ssrc;

    // selection at accept
    logic [SOURCES-1:0] nonempty;
    logic               rr_found;
    logic [SW-1:0]      rr_idx;
    logic [AW-1:0]      sel_head;
    t_kind              sel_kind;
    logic               accept;

    // memory ports
    logic          data_we, next_we;
    logic [AW-1:0] data_waddr, next_waddr;
    logic [DW-1:0] data_wdata, data_rdata;
    logic [AW-1:0] next_wdata, next_rdata, next_raddr;

    // list write-back
    logic          lw_en, lw_broker, clr;
    logic [SW-1:0] lw_idx;
    logic [AW-1:0] lw_head, lw_tail;
    logic [CW-1:0] lw_cnt;

    // result
    t_push_result n_res;
    t_kind        n_kind;
    logic [2:0]   n_ssrc;
    logic [15:0]  n_stag, n_soff;
    logic         n_done, n_restart, n_prog;

    // push helpers
    logic          do_push, push_broker;
    logic [XW-1:0] src_x;
    logic          src_ok;
    logic [SW-1:0] src_idx;
    logic [CW-1:0] p_total, p_bump, p_cnt;
    logic          p_chain;
    logic [AW-1:0] p_head, p_tail, alloc_e;

    // send helpers
    logic [AW-1:0] cur_head, cur_tail;
    logic [CW-1:0] cur_cnt;
    logic [15:0]   rd_tag, rd_len, rd_off;
    logic [16:0]   sum;

    assign accept = start && !busy;
    assign busy   = r_busy;

    always_comb begin
        for (int i = 0; i < SOURCES; i++) begin
            nonempty[i] = (r_s_cnt[i] != '0);
        end
    end

    fpts_rr_pick #(.SOURCES(SOURCES)) u_pick (
        .i_nonempty (nonempty),
        .i_last     (r_last),
        .o_found    (rr_found),
        .o_idx      (rr_idx)
    );

    // broker has strict priority, then round robin, then keep-alive
    always_comb begin
        sel_head = r_s_head[rr_idx];
        if (r_b_cnt != '0) begin
            sel_kind = KIND_BROKER;
            sel_head = r_b_head;
        end else if (rr_found) begin
            sel_kind = KIND_SOURCE;
        end else if (i_timer_expired) begin
            sel_kind = KIND_KEEPALIVE;
        end else begin
            sel_kind = KIND_NONE;
        end
        // pushes read the link of the free chain head, sends the link of the head
        next_raddr = (t_opcode'(i_opcode) == OP_SEND) ? sel_head : r_free_head;
    end

    fpts_ram #(.WIDTH(DW), .DEPTH(POOL_DEPTH)) u_data (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (accept),
        .i_raddr (sel_head),
        .o_rdata (data_rdata)
    );

    fpts_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_next (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (accept),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

    assign rd_tag = data_rdata[DW-1 -: TAG_W];
    assign rd_len = data_rdata[2*LEN_W-1 -: LEN_W];
    assign rd_off = data_rdata[LEN_W-1:0];

    // execute cycle: read data is back, compute result and write back
    always_comb begin
        n_free_head = r_free_head;
        n_bump      = r_bump;
        n_total     = r_total;
        n_last      = r_last;
        n_destroyed = r_destroyed;
        n_link_bad  = r_link_bad;
        data_we = 1'b0; data_waddr = '0; data_wdata = '0;
        next_we = 1'b0; next_waddr = '0; next_wdata = '0;
        lw_en = 1'b0; lw_broker = 1'b0; lw_idx = '0;
        lw_head = '0; lw_tail = '0; lw_cnt = '0;
        clr = 1'b0;
        n_res = PUSH_OK; n_kind = KIND_NONE; n_ssrc = '0;
        n_stag = '0; n_soff = '0;
        n_done = 1'b0; n_restart = 1'b0; n_prog = 1'b0;
        do_push = 1'b0; push_broker = 1'b0;
        src_x   = XW'(r_src);
        src_ok  = src_x < XW'(SOURCES);
        src_idx = src_x[SW-1:0];
        sum = 17'd0;
        cur_head = r_b_head; cur_tail = r_b_tail; cur_cnt = r_b_cnt;
        if (r_kind == KIND_SOURCE) begin
            cur_head = r_s_head[r_ssrc];
            cur_tail = r_s_tail[r_ssrc];
            cur_cnt  = r_s_cnt[r_ssrc];
        end

        if (r_busy) begin
            unique case (r_op)
                OP_PUSH_BROKER: begin
                    do_push = 1'b1;
                    push_broker = 1'b1;
                end
                OP_PUSH_SOURCE: begin
                    if (src_ok) begin
                        do_push = 1'b1;
                    end else begin
                        n_res = PUSH_ERROR;
                    end
                end
                OP_DESTROY: begin
                    clr = 1'b1;
                    n_total = '0;
                    n_bump = '0;
                    n_last = (SW+1)'(SOURCES);
                    n_destroyed = 1'b1;
                    if (r_act == ACT_CONNECT || r_act == ACT_DISCONNECT) begin
                        do_push = 1'b1;
                        push_broker = 1'b1;
                    end
                    if (r_act == ACT_INVALID) begin
                        n_link_bad = 1'b1;
                    end
                end
                OP_SEND: begin
                    n_kind = r_kind;
                    if (r_kind == KIND_BROKER || r_kind == KIND_SOURCE) begin
                        n_stag = rd_tag;
                        n_soff = rd_off;
                        lw_broker = (r_kind == KIND_BROKER);
                        lw_idx = r_ssrc;
                        lw_head = cur_head;
                        lw_tail = cur_tail;
                        lw_cnt = cur_cnt;
                        if (r_kind == KIND_SOURCE) begin
                            n_ssrc = 3'(r_ssrc);
                            n_last = {1'b0, r_ssrc};
                        end
                        if (r_status == LINK_ACCEPTED) begin
                            sum = {1'b0, rd_off} + {1'b0, r_bytes};
                            n_prog = 1'b1;
                            if (sum >= {1'b0, rd_len}) begin
                                // message done: head goes back to the free chain
                                n_done = 1'b1;
                                n_restart = 1'b1;
                                next_we = 1'b1;
                                next_waddr = cur_head;
                                next_wdata = r_free_head;
                                n_free_head = cur_head;
                                n_total = r_total - 1'b1;
                                lw_en = 1'b1;
                                lw_head = next_rdata;
                                lw_cnt = cur_cnt - 1'b1;
                            end else begin
                                data_we = 1'b1;
                                data_waddr = cur_head;
                                data_wdata = {rd_tag, rd_len, sum[15:0]};
                            end
                        end else if (r_status != LINK_BLOCK && r_kind == KIND_SOURCE) begin
                            // hard error: splice the whole source list onto the free chain
                            next_we = 1'b1;
                            next_waddr = cur_tail;
                            next_wdata = r_free_head;
                            n_free_head = cur_head;
                            n_total = r_total - cur_cnt;
                            lw_en = 1'b1;
                            lw_cnt = '0;
                        end
                    end else if (r_kind == KIND_KEEPALIVE) begin
                        if (r_status == LINK_ACCEPTED) begin
                            n_restart = 1'b1;
                            n_prog = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // push, seen through the cleared state on destroy
        p_total = clr ? '0 : r_total;
        p_bump  = clr ? '0 : r_bump;
        p_chain = !clr && (r_bump > r_total);
        if (push_broker) begin
            p_cnt = clr ? '0 : r_b_cnt;
            p_head = r_b_head;
            p_tail = r_b_tail;
        end else begin
            p_cnt = r_s_cnt[src_idx];
            p_head = r_s_head[src_idx];
            p_tail = r_s_tail[src_idx];
        end
        alloc_e = p_chain ? r_free_head : p_bump[AW-1:0];
        if (do_push) begin
            if (r_destroyed) begin
                n_res = PUSH_ERROR;
            end else if ((!r_limitless && QW'(p_total) >= QW'(r_queue_limit))
                         || p_total >= CW'(POOL_DEPTH)) begin
                n_res = PUSH_FULL;
            end else begin
                n_res = PUSH_OK;
                if (p_chain) begin
                    n_free_head = next_rdata;
                end else begin
                    n_bump = p_bump + 1'b1;
                end
                n_total = p_total + 1'b1;
                data_we = 1'b1;
                data_waddr = alloc_e;
                data_wdata = {r_tag, r_len, 16'd0};
                if (p_cnt != '0) begin
                    next_we = 1'b1;
                    next_waddr = p_tail;
                    next_wdata = alloc_e;
                end
                lw_en = 1'b1;
                lw_broker = push_broker;
                lw_idx = src_idx;
                lw_head = (p_cnt == '0) ? alloc_e : p_head;
                lw_tail = alloc_e;
                lw_cnt = p_cnt + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= LIMIT_W'(64);
            r_limitless   <= 1'b0;
            r_b_cnt       <= '0;
            for (int i = 0; i < SOURCES; i++) begin
                r_s_cnt[i] <= '0;
            end
            r_free_head   <= '0;
            r_bump        <= '0;
            r_total       <= '0;
            r_last        <= (SW+1)'(SOURCES);
            r_destroyed   <= 1'b0;
            r_link_bad    <= 1'b0;
            r_busy        <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_QUEUE_LIMIT: r_queue_limit <= i_cfg_data[LIMIT_W-1:0];
                    REG_LIMITLESS:   r_limitless <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_busy <= accept;
            o_valid <= r_busy;
            r_free_head <= n_free_head;
            r_bump <= n_bump;
            r_total <= n_total;
            r_last <= n_last;
            r_destroyed <= n_destroyed;
            r_link_bad <= n_link_bad;
            if (clr) begin
                r_b_cnt <= '0;
                for (int i = 0; i < SOURCES; i++) begin
                    r_s_cnt[i] <= '0;
                end
            end
            if (lw_en) begin
                if (lw_broker) begin
                    r_b_head <= lw_head;
                    r_b_tail <= lw_tail;
                    r_b_cnt <= lw_cnt;
                end else begin
                    r_s_head[lw_idx] <= lw_head;
                    r_s_tail[lw_idx] <= lw_tail;
                    r_s_cnt[lw_idx] <= lw_cnt;
                end
            end
        end
    end

    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_src    <= i_source_id;
            r_tag    <= i_message_tag;
            r_len    <= i_message_length;
            r_bytes  <= i_bytes_accepted;
            r_act    <= t_final_action'(i_final_action);
            r_status <= t_link_status'(i_link_status);
            r_kind   <= sel_kind;
            r_ssrc   <= rr_idx;
        end
        if (r_busy) begin
            o_push_result   <= n_res;
            o_served_kind   <= n_kind;
            o_served_source <= n_ssrc;
            o_served_tag    <= n_stag;
            o_start_offset  <= n_soff;
            o_message_done  <= n_done;
            o_restart_timer <= n_restart;
            o_progress      <= n_prog;
            o_link_invalid  <= n_link_bad;
        end
    end
endmodule
`default_nettype wire

// ----- sv/fpts_checker.sv -----
// fpts_checker: port-level timing and result checks for the scheduler
// uses fpts_pkg; bound to fair_per_source_transmit_scheduler below
`default_nettype none
module fpts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [1:0] o_served_kind,
    input wire logic       o_message_done,
    input wire logic       o_restart_timer,
    input wire logic       o_progress
);
    import fpts_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid) else $error("busy longer than one cycle");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("item without work");

    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_done |-> o_restart_timer && o_progress)
        else $error("done without restart");

    a_none_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_served_kind == KIND_NONE |-> !o_progress && !o_restart_timer)
        else $error("progress with nothing served");
endmodule

bind fair_per_source_transmit_scheduler fpts_checker u_fpts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_served_kind   (o_served_kind),
    .o_message_done  (o_message_done),
    .o_restart_timer (o_restart_timer),
    .o_progress      (o_progress)
);
`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking testbench for fair_per_source_transmit_scheduler
// uses fpts_pkg for codes and widths; drives the command port and checks each result
`default_nettype none
module tb;
    import fpts_pkg::*;

    typedef struct {
        t_opcode       op;
        logic [2:0]    src;
        logic [15:0]   tag;
        logic [15:0]   len;
        t_final_action act;
        t_link_status  status;
        logic [15:0]   bytes;
        logic          timer;
    } t_cmd;

    typedef struct {
        logic [1:0]  push_res;
        logic [1:0]  kind;
        logic [2:0]  src;
        logic [15:0] tag;
        logic [15:0] offset;
        logic        done;
        logic        restart;
        logic        prog;
        logic        invalid;
    } t_sched_res;

    localparam int POOL = 64;
    localparam int NSRC = 8;
    localparam int BROKER_Q = NSRC;    // list index of the broker list
    localparam int PEND_DEPTH = 16;

    // shadow of the scheduler: descriptor pool, lists and flags
    class sched_scoreboard;
        logic [15:0] pool_tag [POOL];
        logic [15:0] pool_len [POOL];
        logic [15:0] pool_off [POOL];
        int          pool_nxt [POOL];
        int          free_head;
        int          q_head [NSRC+1];
        int          q_tail [NSRC+1];
        int          q_cnt  [NSRC+1];
        int          total;
        int          last_src;
        bit          destroyed;
        bit          link_bad;
        int          queue_limit;
        bit          limitless;
        // expected results in order, a small ring
        t_sched_res  pend_buf [PEND_DEPTH];
        int          pend_rd;
        int          pend_wr;
        int          pend_cnt;
        int          errors;

        function void clear_lists();
            for (int i = 0; i < POOL; i++) pool_nxt[i] = (i + 1) % POOL;
            free_head = 0;
            for (int q = 0; q <= NSRC; q++) begin
                q_head[q] = 0; q_tail[q] = 0; q_cnt[q] = 0;
            end
            total = 0;
            last_src = NSRC;
        endfunction

        function void reset_state();
            queue_limit = 64;
            limitless = 0;
            destroyed = 0;
            link_bad = 0;
            errors = 0;
            pend_rd = 0;
            pend_wr = 0;
            pend_cnt = 0;
            clear_lists();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_QUEUE_LIMIT) queue_limit = int'(val);
            else limitless = val[0];
        endfunction

        function logic [1:0] push(int q, logic [15:0] tag, logic [15:0] len);
            int e;
            if (destroyed) return PUSH_ERROR;
            if (!limitless && total >= queue_limit) return PUSH_FULL;
            if (total >= POOL) return PUSH_FULL;
            e = free_head;
            free_head = pool_nxt[e];
            pool_tag[e] = tag;
            pool_len[e] = len;
            pool_off[e] = '0;
            if (q_cnt[q] == 0) q_head[q] = e;
            else pool_nxt[q_tail[q]] = e;
            q_tail[q] = e;
            q_cnt[q]++;
            total++;
            return PUSH_OK;
        endfunction

        function void pop(int q);
            int e;
            e = q_head[q];
            q_head[q] = pool_nxt[e];
            pool_nxt[e] = free_head;
            free_head = e;
            q_cnt[q]--;
            total--;
        endfunction

        // accepted item: work out its result and queue it
        function void note_item(t_cmd c);
            t_sched_res r;
            int q, e, first, s;
            logic [16:0] sum;
            r = '{default: '0};
            case (c.op)
                OP_PUSH_BROKER: r.push_res = push(BROKER_Q, c.tag, c.len);
                OP_PUSH_SOURCE: r.push_res = push(int'(c.src), c.tag, c.len);
                OP_DESTROY: begin
                    clear_lists();
                    if (c.act == ACT_CONNECT || c.act == ACT_DISCONNECT)
                        r.push_res = push(BROKER_Q, c.tag, c.len);
                    else if (c.act == ACT_INVALID)
                        link_bad = 1;
                    destroyed = 1;
                end
                default: begin
                    q = -1;
                    if (q_cnt[BROKER_Q] != 0) begin
                        q = BROKER_Q;
                        r.kind = KIND_BROKER;
                    end else if (total != 0) begin
                        // round robin from the source after the last one picked
                        first = (last_src >= NSRC) ? 0 : last_src + 1;
                        for (int k = 0; k < NSRC && q < 0; k++) begin
                            s = (first + k) % NSRC;
                            if (q_cnt[s] != 0) begin
                                q = s;
                                r.kind = KIND_SOURCE;
                                r.src = 3'(s);
                                last_src = s;
                            end
                        end
                    end
                    if (q >= 0) begin
                        e = q_head[q];
                        r.tag = pool_tag[e];
                        r.offset = pool_off[e];
                        if (c.status == LINK_ACCEPTED) begin
                            sum = {1'b0, pool_off[e]} + {1'b0, c.bytes};
                            if (sum >= {1'b0, pool_len[e]}) begin
                                pop(q);
                                r.done = 1;
                                r.restart = 1;
                            end else begin
                                pool_off[e] = sum[15:0];
                            end
                            r.prog = 1;
                        end else if (c.status != LINK_BLOCK && q != BROKER_Q) begin
                            // hard error drops the whole source list
                            while (q_cnt[q] != 0) pop(q);
                        end
                    end else if (c.timer) begin
                        r.kind = KIND_KEEPALIVE;
                        if (c.status == LINK_ACCEPTED) begin
                            r.restart = 1;
                            r.prog = 1;
                        end
                    end
                end
            endcase
            r.invalid = link_bad;
            if (pend_cnt >= PEND_DEPTH) begin
                $display("%0t: expected result store overflow", $time);
                errors++;
            end else begin
                pend_buf[pend_wr] = r;
                pend_wr = (pend_wr + 1) % PEND_DEPTH;
                pend_cnt++;
            end
        endfunction

        function void check_result(t_sched_res act);
            t_sched_res exp;
            if (pend_cnt == 0) begin
                $display("%0t: unexpected result %p", $time, act);
                errors++;
                return;
            end
            exp = pend_buf[pend_rd];
            pend_rd = (pend_rd + 1) % PEND_DEPTH;
            pend_cnt--;
            if (act.push_res !== exp.push_res || act.kind !== exp.kind ||
                act.src !== exp.src || act.tag !== exp.tag ||
                act.offset !== exp.offset || act.done !== exp.done ||
                act.restart !== exp.restart || act.prog !== exp.prog ||
                act.invalid !== exp.invalid) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp, act);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic [1:0]        i_opcode;
    logic [2:0]        i_source_id;
    logic [15:0]       i_message_tag;
    logic [15:0]       i_message_length;
    logic [1:0]        i_final_action;
    logic [1:0]        i_link_status;
    logic [15:0]       i_bytes_accepted;
    logic              i_timer_expired;
    logic              o_valid;
    logic [1:0]        o_push_result;
    logic [1:0]        o_served_kind;
    logic [2:0]        o_served_source;
    logic [15:0]       o_served_tag;
    logic [15:0]       o_start_offset;
    logic              o_message_done;
    logic              o_restart_timer;
    logic              o_progress;
    logic              o_link_invalid;

    fair_per_source_transmit_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_source_id(i_source_id),
        .i_message_tag(i_message_tag), .i_message_length(i_message_length),
        .i_final_action(i_final_action), .i_link_status(i_link_status),
        .i_bytes_accepted(i_bytes_accepted), .i_timer_expired(i_timer_expired),
        .o_valid(o_valid), .o_push_result(o_push_result),
        .o_served_kind(o_served_kind), .o_served_source(o_served_source),
        .o_served_tag(o_served_tag), .o_start_offset(o_start_offset),
        .o_message_done(o_message_done), .o_restart_timer(o_restart_timer),
        .o_progress(o_progress), .o_link_invalid(o_link_invalid)
    );

    sched_scoreboard sb;
    bit              idle_off;    // long stretch with no gaps between items

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #600000;
        $display("Verification failed");
        $finish;
    end

    // result monitor: results cannot be held off, take every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_push_result, o_served_kind, o_served_source,
                              o_served_tag, o_start_offset, o_message_done,
                              o_restart_timer, o_progress, o_link_invalid});
    end

    // present one item from the falling edge on, hold until accepted
    task automatic drive_item(t_cmd c);
        if (!idle_off && $urandom_range(99) < 28) begin
            @(negedge i_clk);
            start = 0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start = 1;
        i_opcode = c.op;
        i_source_id = c.src;
        i_message_tag = c.tag;
        i_message_length = c.len;
        i_final_action = c.act;
        i_link_status = c.status;
        i_bytes_accepted = c.bytes;
        i_timer_expired = c.timer;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_item(c);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        start = 0;
        while (sb.pend_cnt != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    function automatic t_cmd make_cmd(t_opcode op, int src, int tag, int len,
                                      t_link_status st, int bytes, bit timer,
                                      t_final_action act);
        t_cmd c;
        c.op = op; c.src = 3'(src); c.tag = 16'(tag); c.len = 16'(len);
        c.status = st; c.bytes = 16'(bytes); c.timer = timer; c.act = act;
        return c;
    endfunction

    // random item, pushes slightly ahead of sends so lists build up
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   w;
        c.op = ($urandom_range(99) < 55) ?
               (($urandom_range(3) == 0) ? OP_PUSH_BROKER : OP_PUSH_SOURCE) : OP_SEND;
        c.src = 3'($urandom_range(7));
        c.tag = 16'($urandom);
        w = $urandom_range(19);
        c.len = (w == 0) ? 16'd0 : (w == 1) ? 16'($urandom) : 16'($urandom_range(400, 1));
        w = $urandom_range(19);
        c.bytes = (w == 0) ? 16'($urandom) : (w < 3) ? 16'd0 : 16'($urandom_range(250));
        w = $urandom_range(99);
        c.status = t_link_status'((w < 70) ? LINK_ACCEPTED : (w < 85) ? LINK_BLOCK :
                                  (w < 95) ? LINK_ERROR : LINK_UNKNOWN);
        c.timer = 1'($urandom_range(1));
        c.act = t_final_action'($urandom_range(3));
        return c;
    endfunction

    initial begin
        int limits [7];
        bit frees  [7];
        int n;
        limits = '{64, 8, 1, 0, 127, 3, 64};
        frees = '{0, 0, 0, 0, 0, 1, 0};
        sb = new();
        sb.reset_state();
        idle_off = 0;
        i_rst_n = 0;
        start = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_opcode = '0;
        i_source_id = '0;
        i_message_tag = '0;
        i_message_length = '0;
        i_final_action = '0;
        i_link_status = '0;
        i_bytes_accepted = '0;
        i_timer_expired = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: keep-alive on empty lists, refused and accepted
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_BLOCK, 0, 1, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 0, 1, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 0, 0, ACT_NONE));
        // broker priority, zero length, overshoot, broker error ignored
        drive_item(make_cmd(OP_PUSH_SOURCE, 7, 16'hFFFF, 16'hFFFF, LINK_ACCEPTED, 0, 0,
                            ACT_NONE));
        drive_item(make_cmd(OP_PUSH_SOURCE, 0, 16'h0000, 1, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_PUSH_BROKER, 0, 16'hA5A5, 0, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_PUSH_BROKER, 0, 16'h5A5A, 100, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ERROR, 10, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_UNKNOWN, 10, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 60, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 16'hFFFF, 0, ACT_NONE));
        // round robin across sources, partial progress, would block
        drive_item(make_cmd(OP_PUSH_SOURCE, 3, 16'h1234, 50, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_PUSH_SOURCE, 3, 16'h4321, 5, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 20, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_BLOCK, 20, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 20, 0, ACT_NONE));
        // hard error and unknown status drop a source list
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ERROR, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_UNKNOWN, 0, 1, ACT_NONE));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 0, 1, ACT_NONE));

        // random phases over several limit settings, full cases included
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_QUEUE_LIMIT, CFG_W'(limits[p]));
            write_reg(REG_LIMITLESS, CFG_W'(frees[p]));
            idle_off = (p == 2);
            for (int i = 0; i < 200; i++) drive_item(rand_cmd());
        end
        idle_off = 0;

        // destroy: first one queues a final broker message, later ones fail
        drive_item(make_cmd(OP_DESTROY, 0, 16'hBEEF, 30, LINK_ACCEPTED, 0, 0,
                            ACT_DISCONNECT));
        drive_item(make_cmd(OP_SEND, 0, 0, 1, LINK_ACCEPTED, 10, 0, ACT_NONE));
        drive_item(make_cmd(OP_PUSH_SOURCE, 2, 1, 1, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_DESTROY, 0, 16'h0001, 5, LINK_ACCEPTED, 0, 0, ACT_CONNECT));
        drive_item(make_cmd(OP_DESTROY, 0, 0, 1, LINK_ACCEPTED, 0, 0, ACT_NONE));
        drive_item(make_cmd(OP_DESTROY, 0, 0, 1, LINK_ACCEPTED, 0, 0, ACT_INVALID));
        n = 0;
        while (n < 100) begin
            t_cmd c;
            c = rand_cmd();
            if ($urandom_range(19) == 0) c.op = OP_DESTROY;
            drive_item(c);
            n++;
        end

        @(negedge i_clk);
        start = 0;
        while (sb.pend_cnt != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- fair_per_source_transmit_scheduler.f -----
sv/fpts_pkg.sv
sv/fpts_ram.sv
sv/fpts_rr_pick.sv
sv/fair_per_source_transmit_scheduler.sv
sv/fpts_checker.sv
verif/tb.sv
